### hw/rtl/splw_pkg.sv
package splw_pkg;

  // default geometry
  localparam int unsigned FRAC_BITS_DEF  = 14;
  localparam int unsigned TABLE_BITS_DEF = 6;

  // internal fixed-point formats
  localparam int unsigned LOG_FRAC = 28;
  localparam int unsigned EXP_FRAC = 30;
  localparam int unsigned E_FRAC   = 12;
  localparam int unsigned E_W      = 16;

  // exponent registers reset to 1.0 in Q4.12
  localparam logic [E_W-1:0] EXP_RESET = 16'd4096;

  // register indexes on the config channel
  localparam logic REG_EXPONENT     = 1'b0;
  localparam logic REG_INV_EXPONENT = 1'b1;

  // operation selector codes
  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // per-beat side information carried down the pipeline
  typedef struct packed {
    logic neg;       // input was negative
    logic spec;      // zero or saturating input, result known at decode
    logic spec_one;  // special result magnitude is 1.0 (else 0)
    logic oor;       // input magnitude above 1.0
  } side_t;

  // truncated integer square root
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bt;
    int i;
    res = '0;
    rem = v;
    bt  = 64'h4000_0000_0000_0000;
    for (i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (rem >= res + bt) begin
          rem = rem - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + k/2^t) in Q.28 by repeated squaring
  function automatic logic [63:0] log_node(input int unsigned k, input int unsigned t);
    logic [63:0] z;
    logic [63:0] y;
    int i;
    y = '0;
    if (k >= (32'd1 << t)) return 64'd1 << LOG_FRAC;
    z = (64'(32'd1 << t) + 64'(k)) << (31 - t);
    for (i = 0; i < LOG_FRAC; i++) begin
      z = (z * z) >> 31;
      y = y << 1;
      if (z >= (64'd2 << 31)) begin
        z = z >> 1;
        y = y | 64'd1;
      end
    end
    return y;
  endfunction

  // 2^(k/2^t) in Q.30 as a product of root-of-two factors
  function automatic logic [63:0] exp_node(input int unsigned k, input int unsigned t);
    logic [63:0] r [0:10];
    logic [63:0] acc;
    int j;
    acc  = 64'd1 << EXP_FRAC;
    r[0] = 64'd2 << EXP_FRAC;
    for (j = 1; j <= 10; j++) begin
      if (j <= int'(t)) r[j] = isqrt(r[j-1] << EXP_FRAC);
      else r[j] = '0;
    end
    for (j = 0; j <= 10; j++) begin
      if (j <= int'(t) && ((k >> j) & 1) != 0) acc = (acc * r[int'(t) - j]) >> EXP_FRAC;
    end
    return acc;
  endfunction

endpackage

### hw/rtl/signed_power_law_warp.sv
// Signed power-law warp: result = sign(x)*|x|^e on Q2.FRAC_BITS samples, with e taken from
// the exponent register (operation 0, forward) or the inverse_exponent register (operation 1,
// inverse), both unsigned Q4.12 written over the cfg channel; the user must write them only
// while the block is idle; the block does not enforce this. The power is built as 2^(e*log2|x|)
// from two interpolated tables of 2^TABLE_BITS+1 nodes. Zero maps to zero, magnitudes of 1.0
// and above give exactly +-1.0 and set out_of_range when above 1.0, and results saturate to
// +-1.0; very small results round to zero. The datapath is an 11-stage pipeline that takes one
// beat per clock; when m_axis_tready low holds the output, the whole pipeline stalls in place.
module signed_power_law_warp #(
  parameter int unsigned FRAC_BITS  = splw_pkg::FRAC_BITS_DEF,
  parameter int unsigned TABLE_BITS = splw_pkg::TABLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [splw_pkg::E_W-1:0]              cfg_data,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((FRAC_BITS+2+7)/8)*8-1:0]      s_axis_tdata,  // value
  input  logic                                  s_axis_tuser,  // operation
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((FRAC_BITS+2+7)/8)*8-1:0]      m_axis_tdata,  // result
  output logic                                  m_axis_tuser   // out_of_range
);
  import splw_pkg::*;

  localparam int unsigned V      = FRAC_BITS + 2;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned T      = TABLE_BITS;
  localparam int unsigned IO_W   = ((V + 7) / 8) * 8;
  localparam int unsigned TOP    = 1 << T;
  localparam int unsigned REM_W  = 32 - T;
  localparam int unsigned MUL_W  = 32 + REM_W;
  localparam int unsigned K_W    = $clog2(F + 1);
  localparam int unsigned NL_W   = K_W + LOG_FRAC;
  localparam int unsigned PR_W   = NL_W + E_W - E_FRAC;
  localparam int unsigned N_W    = PR_W - LOG_FRAC;
  localparam int unsigned SH_W   = N_W + 1;
  localparam int unsigned RND_W  = 34;
  localparam int unsigned NS     = 11;

  localparam logic [F:0]   ONE       = {1'b1, {F{1'b0}}};
  localparam logic [V-1:0] ONE_V     = V'(ONE);
  localparam logic [V-1:0] NEG_ONE_V = ~ONE_V + V'(1);

  // constant node tables
  logic [31:0] log_rom [TOP+1];
  logic [31:0] exp_rom [TOP+1];

  for (genvar k = 0; k <= TOP; k++) begin : g_rom
    localparam logic [31:0] LOG_V = 32'(log_node(k, T));
    localparam logic [31:0] EXP_V = 32'(exp_node(k, T));
    assign log_rom[k] = LOG_V;
    assign exp_rom[k] = EXP_V;
  end

  // config registers
  logic [E_W-1:0] exponent;
  logic [E_W-1:0] inverse_exponent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent         <= EXP_RESET;
      inverse_exponent <= EXP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXPONENT:     exponent         <= cfg_data;
        REG_INV_EXPONENT: inverse_exponent <= cfg_data;
        default:          exponent         <= exponent;
      endcase
    end
  end

  // pipeline advance: everything moves unless the output beat is held
  logic          adv;
  logic [NS:1]   vld;
  side_t         side_q [1:NS-1];
  side_t         side_in;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[1] <= side_in;
      for (int i = 2; i <= NS - 1; i++) side_q[i] <= side_q[i-1];
    end
  end

  // stage 1: sign, magnitude, special cases, leading one
  logic [V-1:0]   raw;
  logic [V-1:0]   mag_full;
  logic [K_W-1:0] k_in;
  logic [F-1:0]   s1_mag;
  logic [K_W-1:0] s1_k;
  logic [E_W-1:0] s1_e;

  always_comb begin
    raw      = s_axis_tdata[V-1:0];
    mag_full = raw[V-1] ? (~raw + V'(1)) : raw;
    side_in.neg      = raw[V-1];
    side_in.spec     = (mag_full == '0) || (mag_full >= ONE_V);
    side_in.spec_one = (mag_full >= ONE_V);
    side_in.oor      = (mag_full > ONE_V);
    k_in = '0;
    for (int i = 0; i < int'(F); i++) begin
      if (mag_full[i]) k_in = K_W'(int'(F) - i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mag <= mag_full[F-1:0];
      s1_k   <= k_in;
      s1_e   <= (s_axis_tuser == OP_INVERSE) ? inverse_exponent : exponent;
    end
  end

  // stage 2: normalize to 1.f and widen the fraction to Q.32
  logic [F:0]     norm;
  logic [31:0]    s2_f32;
  logic [K_W-1:0] s2_k;
  logic [E_W-1:0] s2_e;

  assign norm = {1'b0, s1_mag} << s1_k;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_f32 <= 32'(norm[F-1:0]) << (32 - F);
      s2_k   <= s1_k;
      s2_e   <= s1_e;
    end
  end

  // stage 3: log table lookup
  logic [T:0]       lg_idx;
  logic [31:0]      lg_a;
  logic [31:0]      s3_a;
  logic [31:0]      s3_d;
  logic [REM_W-1:0] s3_rem;
  logic [K_W-1:0]   s3_k;
  logic [E_W-1:0]   s3_e;

  assign lg_idx = {1'b0, s2_f32[31:32-T]};
  assign lg_a   = log_rom[lg_idx];

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_a   <= lg_a;
      s3_d   <= log_rom[lg_idx + (T+1)'(1)] - lg_a;
      s3_rem <= s2_f32[REM_W-1:0];
      s3_k   <= s2_k;
      s3_e   <= s2_e;
    end
  end

  // stage 4: log interpolation product
  logic [MUL_W-1:0] s4_prod;
  logic [31:0]      s4_a;
  logic [K_W-1:0]   s4_k;
  logic [E_W-1:0]   s4_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_prod <= MUL_W'(s3_d) * MUL_W'(s3_rem);
      s4_a    <= s3_a;
      s4_k    <= s3_k;
      s4_e    <= s3_e;
    end
  end

  // stage 5: -log2|x| = k - log2(1.f), floored at zero
  logic [31:0]     lf;
  logic [NL_W-1:0] kv;
  logic [NL_W-1:0] lf_w;
  logic [NL_W-1:0] s5_nl;
  logic [E_W-1:0]  s5_e;

  always_comb begin
    lf   = s4_a + 32'(s4_prod >> REM_W);
    kv   = {s4_k, {LOG_FRAC{1'b0}}};
    lf_w = NL_W'(lf);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_nl <= (kv > lf_w) ? (kv - lf_w) : '0;
      s5_e  <= s4_e;
    end
  end

  // stage 6: scale by the exponent
  logic [NL_W+E_W-1:0] full_prod;
  logic [PR_W-1:0]     s6_prod;

  assign full_prod = (NL_W+E_W)'(s5_nl) * (NL_W+E_W)'(s5_e);

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_prod <= full_prod[NL_W+E_W-1:E_FRAC];
    end
  end

  // stage 7: split integer and fraction, exp table lookup on 1 - g
  logic [LOG_FRAC:0] h;
  logic [32:0]       hx;
  logic [T:0]        ex_idx;
  logic [31:0]       ex_a;
  logic [31:0]       s7_a;
  logic [31:0]       s7_d;
  logic [REM_W-1:0]  s7_rem;
  logic [N_W-1:0]    s7_n;

  always_comb begin
    h      = {1'b1, {LOG_FRAC{1'b0}}} - {1'b0, s6_prod[LOG_FRAC-1:0]};
    hx     = {h, 4'b0000};
    ex_idx = hx[32:32-T];
    ex_a   = ex_idx[T] ? exp_rom[TOP] : exp_rom[ex_idx];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_a   <= ex_a;
      s7_d   <= ex_idx[T] ? '0 : (exp_rom[ex_idx + (T+1)'(1)] - ex_a);
      s7_rem <= hx[REM_W-1:0];
      s7_n   <= s6_prod[PR_W-1:LOG_FRAC];
    end
  end

  // stage 8: exp interpolation product
  logic [MUL_W-1:0] s8_prod;
  logic [31:0]      s8_a;
  logic [N_W-1:0]   s8_n;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_prod <= MUL_W'(s7_d) * MUL_W'(s7_rem);
      s8_a    <= s7_a;
      s8_n    <= s7_n;
    end
  end

  // stage 9: mantissa in Q.30
  logic [31:0]    s9_m;
  logic [N_W-1:0] s9_n;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_m <= s8_a + 32'(s8_prod >> REM_W);
      s9_n <= s8_n;
    end
  end

  // stage 10: round half up while shifting down by the integer part
  logic [SH_W-1:0]  sh;
  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] s10_rnd;

  always_comb begin
    sh = SH_W'(31 - int'(F)) + SH_W'(s9_n);
    if (sh >= SH_W'(RND_W)) begin
      rnd = '0;
    end else begin
      rnd = (RND_W'(s9_m) + (RND_W'(1) << (sh - SH_W'(1)))) >> sh;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_rnd <= rnd;
    end
  end

  // stage 11: saturate, special cases, restore sign
  logic [F:0]   mag_r;
  logic [V-1:0] res_u;
  logic [V-1:0] res_v;

  always_comb begin
    mag_r = (s10_rnd > RND_W'(ONE)) ? ONE : s10_rnd[F:0];
    if (side_q[NS-1].spec) mag_r = side_q[NS-1].spec_one ? ONE : '0;
    res_u = V'(mag_r);
    res_v = side_q[NS-1].neg ? (~res_u + V'(1)) : res_u;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= IO_W'(res_v);
      m_axis_tuser <= side_q[NS-1].oor;
    end
  end

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[1])
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_result_bounded: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[V-1:0]) <= $signed(ONE_V) &&
                       $signed(m_axis_tdata[V-1:0]) >= $signed(NEG_ONE_V)))
    else $error("result outside -1.0..1.0");

  a_oor_saturates: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[V-1:0] == ONE_V || m_axis_tdata[V-1:0] == NEG_ONE_V))
    else $error("out of range input did not give +-1.0");

endmodule

### tb/signed_power_law_warp_checker.sv
`timescale 1ns / 100ps

module signed_power_law_warp_checker #(
  parameter int unsigned FRAC_BITS  = splw_pkg::FRAC_BITS_DEF,
  parameter int unsigned TABLE_BITS = splw_pkg::TABLE_BITS_DEF,
  parameter int unsigned DATA_W     = ((FRAC_BITS + 2 + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [splw_pkg::E_W-1:0] cfg_data,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [DATA_W-1:0]       s_tdata,   // value
  input  logic                    s_tuser,   // operation
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [DATA_W-1:0]       m_tdata,   // result
  input  logic                    m_tuser,   // out_of_range
  output int                      pending,
  output int                      errors
);

  localparam int unsigned VAL_W = FRAC_BITS + 2;
  localparam int unsigned NODES = 1 << TABLE_BITS;
  localparam int unsigned LOG_FRAC = splw_pkg::LOG_FRAC;
  localparam int unsigned EXP_FRAC = splw_pkg::EXP_FRAC;

  typedef struct packed {
    logic [VAL_W-1:0] result;
    logic             out_of_range;
  } warp_out_t;

  logic [63:0] log_rom [0:NODES];
  logic [63:0] exp_rom [0:NODES];

  logic [splw_pkg::E_W-1:0] fwd_exp = splw_pkg::EXP_RESET;
  logic [splw_pkg::E_W-1:0] inv_exp = splw_pkg::EXP_RESET;

  warp_out_t expected_warps [$];
  warp_out_t want;

  initial pending = 0;
  initial errors  = 0;

  // truncated integer square root
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] acc;
    logic [63:0] rest;
    logic [63:0] probe;
    acc   = '0;
    rest  = v;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= acc + probe) begin
        rest = rest - (acc + probe);
        acc  = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    return acc;
  endfunction

  // log2(1 + k/2^T) in Q.28, bit by bit through repeated squaring
  function automatic logic [63:0] log2_node(input int unsigned k);
    logic [63:0] z;
    logic [63:0] y;
    int i;
    y = '0;
    if (k >= NODES) return 64'd1 << LOG_FRAC;
    z = 64'(NODES + k) << (31 - TABLE_BITS);
    for (i = 0; i < LOG_FRAC; i++) begin
      z = (z * z) >> 31;
      y = y << 1;
      if (z >= (64'd2 << 31)) begin
        z = z >> 1;
        y = y | 64'd1;
      end
    end
    return y;
  endfunction

  // 2^(k/2^T) in Q.30 as a product of repeated square roots of two
  function automatic logic [63:0] exp2_node(input int unsigned k);
    logic [63:0] root [0:TABLE_BITS];
    logic [63:0] acc;
    int j;
    root[0] = 64'd2 << EXP_FRAC;
    for (j = 1; j <= TABLE_BITS; j++) root[j] = root_floor(root[j-1] << EXP_FRAC);
    acc = 64'd1 << EXP_FRAC;
    for (j = 0; j <= TABLE_BITS; j++) begin
      if (((k >> j) & 1) != 0) acc = (acc * root[TABLE_BITS - j]) >> EXP_FRAC;
    end
    return acc;
  endfunction

  // fill both tables once
  initial begin
    for (int k = 0; k <= NODES; k++) begin
      log_rom[k] = log2_node(k);
      exp_rom[k] = exp2_node(k);
    end
  end

  // linear interpolation on a Q.32 operand
  function automatic logic [63:0] rom_lookup(input logic [63:0] x32, input bit from_exp);
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] lo;
    logic [63:0] hi;
    idx  = x32 >> (32 - TABLE_BITS);
    frac = x32 & ((64'd1 << (32 - TABLE_BITS)) - 64'd1);
    if (idx >= NODES) return from_exp ? exp_rom[NODES] : log_rom[NODES];
    lo = from_exp ? exp_rom[idx] : log_rom[idx];
    hi = from_exp ? exp_rom[idx + 1] : log_rom[idx + 1];
    return lo + (((hi - lo) * frac) >> (32 - TABLE_BITS));
  endfunction

  // sign(x)*|x|^e via 2^(e*log2|x|)
  function automatic warp_out_t warp_predict(input logic op, input logic [VAL_W-1:0] raw);
    warp_out_t   o;
    logic        neg;
    logic [VAL_W-1:0] neg_raw;
    logic [63:0] one, mag, e, mant, f32, lf, nl, prod, n, g, h, m, shift, res;
    int          p;
    one     = 64'd1 << FRAC_BITS;
    neg     = raw[VAL_W-1];
    neg_raw = ~raw + 1'b1;
    mag     = neg ? 64'(neg_raw) : 64'(raw);
    e       = (op == splw_pkg::OP_INVERSE) ? 64'(inv_exp) : 64'(fwd_exp);
    o.out_of_range = 1'b0;
    if (mag == 0) begin
      res = '0;
    end else if (mag >= one) begin
      // saturated input, flag only above 1.0
      o.out_of_range = (mag > one);
      res = one;
    end else begin
      p = 0;
      while ((mag >> (p + 1)) != 0) p++;
      mant = mag << (FRAC_BITS - p);
      f32  = (mant - one) << (32 - FRAC_BITS);
      lf   = rom_lookup(f32, 1'b0);
      nl   = 64'(FRAC_BITS - p) << LOG_FRAC;
      nl   = (nl > lf) ? nl - lf : 64'd0;
      prod = (nl * e) >> splw_pkg::E_FRAC;
      n    = prod >> LOG_FRAC;
      g    = prod & ((64'd1 << LOG_FRAC) - 64'd1);
      h    = (64'd1 << LOG_FRAC) - g;
      m    = rom_lookup(h << (32 - LOG_FRAC), 1'b1);
      shift = 64'(EXP_FRAC - FRAC_BITS) + n + 64'd1;
      // round half up, far shifts underflow to zero
      if (shift >= 63) res = '0;
      else res = (m + (64'd1 << (shift - 1))) >> shift;
      if (res > one) res = one;
    end
    if (neg) res = ~res + 64'd1;
    o.result = res[VAL_W-1:0];
    return o;
  endfunction

  // track config, queue predictions, compare results
  always @(posedge clk) begin
    if (rst) begin
      fwd_exp = splw_pkg::EXP_RESET;
      inv_exp = splw_pkg::EXP_RESET;
      expected_warps.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == splw_pkg::REG_EXPONENT) fwd_exp = cfg_data;
        else inv_exp = cfg_data;
      end
      if (s_tvalid && s_tready)
        expected_warps.push_back(warp_predict(s_tuser, s_tdata[VAL_W-1:0]));
      if (m_tvalid && m_tready) begin
        if (expected_warps.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: result %h out_of_range %b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected_warps.pop_front();
          if (m_tdata[VAL_W-1:0] !== want.result) begin
            errors++;
            $display("%0t: result mismatch: expected %h actual %h",
                     $time, want.result, m_tdata[VAL_W-1:0]);
          end
          if (m_tuser !== want.out_of_range) begin
            errors++;
            $display("%0t: out_of_range mismatch: expected %b actual %b",
                     $time, want.out_of_range, m_tuser);
          end
        end
      end
    end
    pending <= expected_warps.size();
  end

endmodule

### tb/signed_power_law_warp_tb.sv
`timescale 1ns / 100ps

module signed_power_law_warp_tb;

  localparam int unsigned FRAC_BITS  = splw_pkg::FRAC_BITS_DEF;
  localparam int unsigned TABLE_BITS = splw_pkg::TABLE_BITS_DEF;
  localparam int unsigned DATA_W     = ((FRAC_BITS + 2 + 7) / 8) * 8;
  localparam int unsigned VAL_W      = FRAC_BITS + 2;
  localparam int          ONE        = 1 << FRAC_BITS;
  localparam int          EDGE_COUNT = 12;
  localparam int          NUM_PHASES = 10;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          DRAIN_CYCLES = 30;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_index = splw_pkg::REG_EXPONENT;
  logic [splw_pkg::E_W-1:0] cfg_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [DATA_W-1:0]        s_axis_tdata = '0;  // value
  logic                     s_axis_tuser = splw_pkg::OP_FORWARD;  // operation
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [DATA_W-1:0]        m_axis_tdata;  // result
  logic                     m_axis_tuser;  // out_of_range

  logic steady = 1'b0;
  int   pending;
  int   errors;
  int   quiet_cycles = 0;

  signed_power_law_warp #(
    .FRAC_BITS (FRAC_BITS),
    .TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  signed_power_law_warp_checker #(
    .FRAC_BITS (FRAC_BITS),
    .TABLE_BITS(TABLE_BITS)
  ) scoreboard (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser),
    .pending  (pending),
    .errors   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output back-pressure
  always @(posedge clk) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // boundary values of the Q2.14 input
  function automatic logic [VAL_W-1:0] edge_value(input int k);
    case (k)
      0:       return VAL_W'(0);
      1:       return VAL_W'(ONE);
      2:       return VAL_W'(-ONE);
      3:       return VAL_W'(ONE + 1);
      4:       return VAL_W'(-(ONE + 1));
      5:       return VAL_W'((1 << (VAL_W - 1)) - 1);
      6:       return VAL_W'(-(1 << (VAL_W - 1)));
      7:       return VAL_W'(1);
      8:       return VAL_W'(-1);
      9:       return VAL_W'(ONE - 1);
      10:      return VAL_W'(-(ONE - 1));
      default: return VAL_W'(ONE / 2);
    endcase
  endfunction

  // half nominal range, some full range, small magnitudes and boundaries
  function automatic logic [VAL_W-1:0] random_value();
    int sel;
    int mag;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      mag = $urandom_range(0, 2 * ONE);
      return VAL_W'(mag - ONE);
    end else if (sel < 65) begin
      return VAL_W'($urandom);
    end else if (sel < 85) begin
      mag = $urandom_range(1, 1 << $urandom_range(0, FRAC_BITS - 2));
      return $urandom_range(0, 1) ? VAL_W'(-mag) : VAL_W'(mag);
    end else begin
      return edge_value($urandom_range(0, EDGE_COUNT - 1));
    end
  endfunction

  // one input beat with an optional idle gap before it
  task automatic push_sample(input logic op, input logic [VAL_W-1:0] val);
    if (!steady) begin
      while ($urandom_range(0, 99) < 25) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(val);
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // write both exponent registers back to back
  task automatic load_exponents(input logic [splw_pkg::E_W-1:0] fwd,
                                input logic [splw_pkg::E_W-1:0] inv);
    cfg_valid <= 1'b1;
    cfg_index <= splw_pkg::REG_EXPONENT;
    cfg_data  <= fwd;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= splw_pkg::REG_INV_EXPONENT;
    cfg_data  <= inv;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int count;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // exponent settings per phase, phase 0 keeps the reset values
      case (ph)
        1:       load_exponents(16'hFFFF, 16'd1);
        2:       load_exponents(16'd1, 16'hFFFF);
        3:       load_exponents(16'd8192, 16'd2048);
        4:       load_exponents(16'd2048, 16'd8192);
        5:       load_exponents(16'd12288, 16'd1365);
        6:       load_exponents(16'd0, 16'd0);
        7, 8:    load_exponents(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        9:       load_exponents(splw_pkg::EXP_RESET, splw_pkg::EXP_RESET);
        default: ;
      endcase
      steady <= (ph == 3);

      // boundary values through both operations, tiny results underflow here
      if (ph == 1) begin
        for (int k = 0; k < EDGE_COUNT; k++) begin
          push_sample(splw_pkg::OP_FORWARD, edge_value(k));
          push_sample(splw_pkg::OP_INVERSE, edge_value(k));
        end
      end

      count = (ph == 6) ? 30 : ((ph == 0 || ph == 9) ? 40 : 60);
      for (int i = 0; i < count; i++)
        push_sample($urandom_range(0, 1) ? splw_pkg::OP_INVERSE : splw_pkg::OP_FORWARD,
                    random_value());
      s_axis_tvalid <= 1'b0;

      // let the pipeline empty before touching the registers
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/splw_pkg.sv
hw/rtl/signed_power_law_warp.sv
tb/signed_power_law_warp_checker.sv
tb/signed_power_law_warp_tb.sv
